FILE: rtl/line_sphere_intersection_top_macros.svh
// Assertion macros for the line / sphere intersection block.
// Used by line_sphere_intersection_top; expects clk and rst_n in scope.
`ifndef LINE_SPHERE_INTERSECTION_TOP_MACROS_SVH
`define LINE_SPHERE_INTERSECTION_TOP_MACROS_SVH

// Same-cycle implication, muted during reset
`define LSI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, muted during reset
`define LSI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lsi_pkg.sv
// Shared types, widths and constants for the line / sphere intersection block.
// No dependencies; the module files refer to it by scoped names.
`timescale 1ns / 1ps

package lsi_pkg;

  // Defaults for the top-level parameters
  localparam int DIMENSIONS_DEF = 3;
  localparam int FRAC_BITS_DEF  = 16;

  // Field and datapath widths
  localparam int COORD_W    = 32;
  localparam int RAD_W      = 31;
  localparam int DLT_W      = COORD_W + 1;
  localparam int AA_W       = 2 * COORD_W - 1;
  localparam int BB_W       = COORD_W + DLT_W;
  localparam int CC_W       = 2 * COORD_W + 1;
  localparam int RR_W       = 2 * RAD_W;
  localparam int A_W        = 64;
  localparam int BH_W       = 67;
  localparam int MAG_W      = 66;
  localparam int DIG_W      = 16;
  localparam int MUL_DIGITS = (MAG_W + DIG_W - 1) / DIG_W;
  localparam int YP_W       = MUL_DIGITS * DIG_W;
  localparam int PROD_W     = 2 * MAG_W;
  localparam int Q_W        = 134;
  localparam int ROOT_W     = Q_W / 2;
  localparam int SREM_W     = ROOT_W + 2;
  localparam int NUM_W      = 70;
  localparam int NMAG_W     = NUM_W - 1;
  localparam int DEN_W      = A_W + 1;
  localparam int QUO_W      = 32;

  // Root count codes
  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;

  // Clamp limits on the quotient magnitude
  localparam logic [QUO_W-1:0] LIM_POS = 32'h7FFF_FFFF;
  localparam logic [QUO_W-1:0] LIM_NEG = 32'h8000_0000;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic signed [COORD_W-1:0] dir_x;
    logic signed [COORD_W-1:0] dir_y;
    logic signed [COORD_W-1:0] dir_z;
    logic signed [COORD_W-1:0] centre_x;
    logic signed [COORD_W-1:0] centre_y;
    logic signed [COORD_W-1:0] centre_z;
    logic        [RAD_W-1:0]   radius;
  } in_t;

  typedef struct packed {
    logic        [1:0]       root_count;
    logic signed [QUO_W-1:0] root_first;
    logic signed [QUO_W-1:0] root_second;
    logic                    divide_fault;
    logic                    saturated;
  } out_t;

  // Side data riding along the multiply chain
  typedef struct packed {
    logic signed [BH_W-1:0] bh;
    logic [A_W-1:0]         a;
    logic                   cneg;
  } coef_tag_t;

  // Side data riding along the square-root chain
  typedef struct packed {
    logic signed [BH_W-1:0] bh;
    logic [A_W-1:0]         a;
    logic                   qneg;
    logic                   qzero;
  } sq_tag_t;

  // Side data riding along the divider chain
  typedef struct packed {
    logic [1:0] cnt;
    logic       fault;
    logic       neg0;
    logic       neg1;
    logic       big0;
    logic       big1;
  } div_tag_t;

endpackage

FILE: rtl/lsi_mul_cell.sv
// One digit step of two parallel multiply-accumulate chains.
// Depends on lsi_pkg for widths and the coefficient tag type.
`timescale 1ns / 1ps

module lsi_mul_cell #(
  parameter int POS = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          vld_i,
  input  lsi_pkg::coef_tag_t            tag_i,
  input  logic [lsi_pkg::MAG_W-1:0]     x0_i,
  input  logic [lsi_pkg::YP_W-1:0]      y0_i,
  input  logic [lsi_pkg::PROD_W-1:0]    acc0_i,
  input  logic [lsi_pkg::MAG_W-1:0]     x1_i,
  input  logic [lsi_pkg::YP_W-1:0]      y1_i,
  input  logic [lsi_pkg::PROD_W-1:0]    acc1_i,
  output logic                          vld_o,
  output lsi_pkg::coef_tag_t            tag_o,
  output logic [lsi_pkg::MAG_W-1:0]     x0_o,
  output logic [lsi_pkg::YP_W-1:0]      y0_o,
  output logic [lsi_pkg::PROD_W-1:0]    acc0_o,
  output logic [lsi_pkg::MAG_W-1:0]     x1_o,
  output logic [lsi_pkg::YP_W-1:0]      y1_o,
  output logic [lsi_pkg::PROD_W-1:0]    acc1_o
);

  localparam int PP_W = lsi_pkg::MAG_W + lsi_pkg::DIG_W;

  logic [PP_W-1:0]            pp0, pp1;
  logic [lsi_pkg::PROD_W-1:0] acc0_nxt, acc1_nxt;
  logic                       vld_r;
  lsi_pkg::coef_tag_t         tag_r;
  logic [lsi_pkg::MAG_W-1:0]  x0_r, x1_r;
  logic [lsi_pkg::YP_W-1:0]   y0_r, y1_r;
  logic [lsi_pkg::PROD_W-1:0] acc0_r, acc1_r;

  // Multiply by this cell's digit and add at its weight
  always_comb begin
    pp0 = x0_i * y0_i[POS*lsi_pkg::DIG_W +: lsi_pkg::DIG_W];
    pp1 = x1_i * y1_i[POS*lsi_pkg::DIG_W +: lsi_pkg::DIG_W];
    acc0_nxt = acc0_i + (lsi_pkg::PROD_W'(pp0) << (POS * lsi_pkg::DIG_W));
    acc1_nxt = acc1_i + (lsi_pkg::PROD_W'(pp1) << (POS * lsi_pkg::DIG_W));
  end

  // Advance valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      tag_r  <= tag_i;
      x0_r   <= x0_i;
      y0_r   <= y0_i;
      acc0_r <= acc0_nxt;
      x1_r   <= x1_i;
      y1_r   <= y1_i;
      acc1_r <= acc1_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign tag_o  = tag_r;
  assign x0_o   = x0_r;
  assign y0_o   = y0_r;
  assign acc0_o = acc0_r;
  assign x1_o   = x1_r;
  assign y1_o   = y1_r;
  assign acc1_o = acc1_r;

endmodule

FILE: rtl/lsi_sqrt_cell.sv
// One bit step of a restoring integer square root.
// Depends on lsi_pkg for widths and the square-root tag type.
`timescale 1ns / 1ps

module lsi_sqrt_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         vld_i,
  input  lsi_pkg::sq_tag_t             tag_i,
  input  logic [lsi_pkg::Q_W-1:0]      rad_i,
  input  logic [lsi_pkg::ROOT_W-1:0]   root_i,
  input  logic [lsi_pkg::SREM_W-1:0]   rem_i,
  output logic                         vld_o,
  output lsi_pkg::sq_tag_t             tag_o,
  output logic [lsi_pkg::Q_W-1:0]      rad_o,
  output logic [lsi_pkg::ROOT_W-1:0]   root_o,
  output logic [lsi_pkg::SREM_W-1:0]   rem_o
);

  localparam int W2 = lsi_pkg::SREM_W + 2;

  logic [W2-1:0]                 rem2, trial, diff;
  logic                          ge;
  logic                          vld_r;
  lsi_pkg::sq_tag_t              tag_r;
  logic [lsi_pkg::Q_W-1:0]       rad_r;
  logic [lsi_pkg::ROOT_W-1:0]    root_r;
  logic [lsi_pkg::SREM_W-1:0]    rem_r;

  // Bring down two radicand bits and try the next root bit
  always_comb begin
    rem2  = {rem_i, rad_i[lsi_pkg::Q_W-1 -: 2]};
    trial = W2'({root_i, 2'b01});
    ge    = rem2 >= trial;
    diff  = rem2 - trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  // Advance remainder, root and the rest of the radicand
  always_ff @(posedge clk) begin
    if (en) begin
      tag_r  <= tag_i;
      rad_r  <= rad_i << 2;
      root_r <= {root_i[lsi_pkg::ROOT_W-2:0], ge};
      rem_r  <= ge ? diff[lsi_pkg::SREM_W-1:0] : rem2[lsi_pkg::SREM_W-1:0];
    end
  end

  assign vld_o  = vld_r;
  assign tag_o  = tag_r;
  assign rad_o  = rad_r;
  assign root_o = root_r;
  assign rem_o  = rem_r;

endmodule

FILE: rtl/lsi_div_cell.sv
// One quotient bit step of two restoring dividers sharing a divisor.
// Depends on lsi_pkg for widths and the divider tag type.
`timescale 1ns / 1ps

module lsi_div_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         vld_i,
  input  lsi_pkg::div_tag_t            tag_i,
  input  logic [lsi_pkg::DEN_W-1:0]    den_i,
  input  logic [lsi_pkg::DEN_W-1:0]    rem0_i,
  input  logic [lsi_pkg::QUO_W-1:0]    lo0_i,
  input  logic [lsi_pkg::QUO_W-1:0]    q0_i,
  input  logic [lsi_pkg::DEN_W-1:0]    rem1_i,
  input  logic [lsi_pkg::QUO_W-1:0]    lo1_i,
  input  logic [lsi_pkg::QUO_W-1:0]    q1_i,
  output logic                         vld_o,
  output lsi_pkg::div_tag_t            tag_o,
  output logic [lsi_pkg::DEN_W-1:0]    den_o,
  output logic [lsi_pkg::DEN_W-1:0]    rem0_o,
  output logic [lsi_pkg::QUO_W-1:0]    lo0_o,
  output logic [lsi_pkg::QUO_W-1:0]    q0_o,
  output logic [lsi_pkg::DEN_W-1:0]    rem1_o,
  output logic [lsi_pkg::QUO_W-1:0]    lo1_o,
  output logic [lsi_pkg::QUO_W-1:0]    q1_o
);

  localparam int W2 = lsi_pkg::DEN_W + 1;

  logic [W2-1:0]               r0, r1, d0, d1, dext;
  logic                        ge0, ge1;
  logic                        vld_r;
  lsi_pkg::div_tag_t           tag_r;
  logic [lsi_pkg::DEN_W-1:0]   den_r, rem0_r, rem1_r;
  logic [lsi_pkg::QUO_W-1:0]   lo0_r, lo1_r, q0_r, q1_r;

  // Shift in the next dividend bit and compare against the divisor
  always_comb begin
    dext = {1'b0, den_i};
    r0   = {rem0_i, lo0_i[lsi_pkg::QUO_W-1]};
    r1   = {rem1_i, lo1_i[lsi_pkg::QUO_W-1]};
    ge0  = r0 >= dext;
    ge1  = r1 >= dext;
    d0   = r0 - dext;
    d1   = r1 - dext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  // Advance partial remainders and quotients
  always_ff @(posedge clk) begin
    if (en) begin
      tag_r  <= tag_i;
      den_r  <= den_i;
      rem0_r <= ge0 ? d0[lsi_pkg::DEN_W-1:0] : r0[lsi_pkg::DEN_W-1:0];
      rem1_r <= ge1 ? d1[lsi_pkg::DEN_W-1:0] : r1[lsi_pkg::DEN_W-1:0];
      lo0_r  <= lo0_i << 1;
      lo1_r  <= lo1_i << 1;
      q0_r   <= {q0_i[lsi_pkg::QUO_W-2:0], ge0};
      q1_r   <= {q1_i[lsi_pkg::QUO_W-2:0], ge1};
    end
  end

  assign vld_o  = vld_r;
  assign tag_o  = tag_r;
  assign den_o  = den_r;
  assign rem0_o = rem0_r;
  assign lo0_o  = lo0_r;
  assign q0_o   = q0_r;
  assign rem1_o = rem1_r;
  assign lo1_o  = lo1_r;
  assign q1_o   = q1_r;

endmodule

FILE: rtl/line_sphere_intersection_top.sv
// Line / sphere intersection: pipeline of coefficient stages and cell chains.
// Depends on lsi_pkg, lsi_mul_cell, lsi_sqrt_cell, lsi_div_cell and the macro header.
`timescale 1ns / 1ps

// Solves a*t^2 + b*t + c = 0 for a line against a sphere, all in signed fixed point,
// and returns one result per request. Throughput is one request per clock while the
// pipeline is not held. Its longest part is the 67-cell square-root chain, with 5
// multiply cells before it and the 32-cell divider chain after it. The pipeline
// advances as a whole and only holds when a result sits in the output register
// unclaimed while the last stage is also full; while the last stage is empty the
// pipeline keeps advancing even if the output register waits.

`include "line_sphere_intersection_top_macros.svh"

module line_sphere_intersection_top #(
  parameter int DIMENSIONS = lsi_pkg::DIMENSIONS_DEF,
  parameter int FRAC_BITS  = lsi_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  lsi_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output lsi_pkg::out_t  out_data
);

  localparam int SHR = lsi_pkg::COORD_W - FRAC_BITS;
  localparam int ND  = lsi_pkg::MUL_DIGITS;
  localparam int NR  = lsi_pkg::ROOT_W;
  localparam int NQ  = lsi_pkg::QUO_W;

  logic adv;
  logic v_last;
  logic out_free;

  // ---------------- stage 1: differences ----------------
  logic signed [lsi_pkg::COORD_W-1:0] org [3];
  logic signed [lsi_pkg::COORD_W-1:0] dvec [3];
  logic signed [lsi_pkg::COORD_W-1:0] cen [3];

  assign org[0]  = in_data.origin_x;
  assign org[1]  = in_data.origin_y;
  assign org[2]  = in_data.origin_z;
  assign dvec[0] = in_data.dir_x;
  assign dvec[1] = in_data.dir_y;
  assign dvec[2] = in_data.dir_z;
  assign cen[0]  = in_data.centre_x;
  assign cen[1]  = in_data.centre_y;
  assign cen[2]  = in_data.centre_z;

  logic                               s1_vld_r;
  logic signed [lsi_pkg::COORD_W-1:0] dir_s1_r [DIMENSIONS];
  logic signed [lsi_pkg::DLT_W-1:0]   dlt_s1_r [DIMENSIONS];
  logic [lsi_pkg::RAD_W-1:0]          rad_s1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < DIMENSIONS; i++) begin
        dir_s1_r[i] <= dvec[i];
        dlt_s1_r[i] <= {org[i][lsi_pkg::COORD_W-1], org[i]}
                     - {cen[i][lsi_pkg::COORD_W-1], cen[i]};
      end
      rad_s1_r <= in_data.radius;
    end
  end

  // ---------------- stage 2: products ----------------
  logic                             s2_vld_r;
  logic [lsi_pkg::AA_W-1:0]         aa_s2_r [DIMENSIONS];
  logic signed [lsi_pkg::BB_W-1:0]  bb_s2_r [DIMENSIONS];
  logic [lsi_pkg::CC_W-1:0]         cc_s2_r [DIMENSIONS];
  logic [lsi_pkg::RR_W-1:0]         rr_s2_r;

  logic signed [2*lsi_pkg::COORD_W-1:0] aa_p [DIMENSIONS];
  logic signed [lsi_pkg::BB_W-1:0]      bb_p [DIMENSIONS];
  logic signed [2*lsi_pkg::DLT_W-1:0]   cc_p [DIMENSIONS];

  always_comb begin
    for (int i = 0; i < DIMENSIONS; i++) begin
      aa_p[i] = dir_s1_r[i] * dir_s1_r[i];
      bb_p[i] = dir_s1_r[i] * dlt_s1_r[i];
      cc_p[i] = dlt_s1_r[i] * dlt_s1_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < DIMENSIONS; i++) begin
        aa_s2_r[i] <= aa_p[i][lsi_pkg::AA_W-1:0];
        bb_s2_r[i] <= bb_p[i];
        cc_s2_r[i] <= cc_p[i][lsi_pkg::CC_W-1:0];
      end
      rr_s2_r <= rad_s1_r * rad_s1_r;
    end
  end

  // ---------------- stage 3: coefficient sums ----------------
  logic [lsi_pkg::A_W-1:0]          a_sum;
  logic signed [lsi_pkg::BH_W-1:0]  bh_sum, c_sum;
  logic [lsi_pkg::MAG_W-1:0]        bmag, cmag;

  always_comb begin
    a_sum  = '0;
    bh_sum = '0;
    c_sum  = '0;
    for (int i = 0; i < DIMENSIONS; i++) begin
      a_sum  = a_sum + lsi_pkg::A_W'(aa_s2_r[i]);
      bh_sum = bh_sum + lsi_pkg::BH_W'(bb_s2_r[i]);
      c_sum  = c_sum + $signed({2'b00, cc_s2_r[i]});
    end
    c_sum = c_sum - $signed({5'b00000, rr_s2_r});
    bmag  = bh_sum[lsi_pkg::BH_W-1] ? lsi_pkg::MAG_W'(-bh_sum) : bh_sum[lsi_pkg::MAG_W-1:0];
    cmag  = c_sum[lsi_pkg::BH_W-1]  ? lsi_pkg::MAG_W'(-c_sum)  : c_sum[lsi_pkg::MAG_W-1:0];
  end

  logic                       s3_vld_r;
  lsi_pkg::coef_tag_t         s3_tag_r;
  logic [lsi_pkg::MAG_W-1:0]  bmag_s3_r, cmag_s3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_tag_r.bh   <= bh_sum;
      s3_tag_r.a    <= a_sum;
      s3_tag_r.cneg <= c_sum[lsi_pkg::BH_W-1];
      bmag_s3_r     <= bmag;
      cmag_s3_r     <= cmag;
    end
  end

  // ---------------- multiply chain: Bh^2 and A*|C| ----------------
  logic                        m_vld  [ND+1];
  lsi_pkg::coef_tag_t          m_tag  [ND+1];
  logic [lsi_pkg::MAG_W-1:0]   m_x0   [ND+1];
  logic [lsi_pkg::YP_W-1:0]    m_y0   [ND+1];
  logic [lsi_pkg::PROD_W-1:0]  m_acc0 [ND+1];
  logic [lsi_pkg::MAG_W-1:0]   m_x1   [ND+1];
  logic [lsi_pkg::YP_W-1:0]    m_y1   [ND+1];
  logic [lsi_pkg::PROD_W-1:0]  m_acc1 [ND+1];

  assign m_vld[0]  = s3_vld_r;
  assign m_tag[0]  = s3_tag_r;
  assign m_x0[0]   = bmag_s3_r;
  assign m_y0[0]   = lsi_pkg::YP_W'(bmag_s3_r);
  assign m_acc0[0] = '0;
  assign m_x1[0]   = cmag_s3_r;
  assign m_y1[0]   = lsi_pkg::YP_W'(s3_tag_r.a);
  assign m_acc1[0] = '0;

  for (genvar k = 0; k < ND; k++) begin : g_mul
    lsi_mul_cell #(.POS(k)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .vld_i  (m_vld[k]),
      .tag_i  (m_tag[k]),
      .x0_i   (m_x0[k]),
      .y0_i   (m_y0[k]),
      .acc0_i (m_acc0[k]),
      .x1_i   (m_x1[k]),
      .y1_i   (m_y1[k]),
      .acc1_i (m_acc1[k]),
      .vld_o  (m_vld[k+1]),
      .tag_o  (m_tag[k+1]),
      .x0_o   (m_x0[k+1]),
      .y0_o   (m_y0[k+1]),
      .acc0_o (m_acc0[k+1]),
      .x1_o   (m_x1[k+1]),
      .y1_o   (m_y1[k+1]),
      .acc1_o (m_acc1[k+1])
    );
  end

  // ---------------- discriminant stage ----------------
  logic signed [lsi_pkg::Q_W-1:0] qs;

  always_comb begin
    if (m_tag[ND].cneg) begin
      qs = $signed(lsi_pkg::Q_W'(m_acc0[ND])) + $signed(lsi_pkg::Q_W'(m_acc1[ND]));
    end else begin
      qs = $signed(lsi_pkg::Q_W'(m_acc0[ND])) - $signed(lsi_pkg::Q_W'(m_acc1[ND]));
    end
  end

  logic                      qd_vld_r;
  lsi_pkg::sq_tag_t          qd_tag_r;
  logic [lsi_pkg::Q_W-1:0]   qd_rad_r;

  // Drop a negative discriminant to zero; scale by four otherwise
  always_ff @(posedge clk) begin
    if (adv) begin
      qd_tag_r.bh    <= m_tag[ND].bh;
      qd_tag_r.a     <= m_tag[ND].a;
      qd_tag_r.qneg  <= qs[lsi_pkg::Q_W-1];
      qd_tag_r.qzero <= (qs == '0);
      qd_rad_r       <= qs[lsi_pkg::Q_W-1] ? '0 : {qs[lsi_pkg::Q_W-3:0], 2'b00};
    end
  end

  // ---------------- square-root chain ----------------
  logic                        s_vld  [NR+1];
  lsi_pkg::sq_tag_t            s_tag  [NR+1];
  logic [lsi_pkg::Q_W-1:0]     s_rad  [NR+1];
  logic [lsi_pkg::ROOT_W-1:0]  s_root [NR+1];
  logic [lsi_pkg::SREM_W-1:0]  s_rem  [NR+1];

  assign s_vld[0]  = qd_vld_r;
  assign s_tag[0]  = qd_tag_r;
  assign s_rad[0]  = qd_rad_r;
  assign s_root[0] = '0;
  assign s_rem[0]  = '0;

  for (genvar k = 0; k < NR; k++) begin : g_sqrt
    lsi_sqrt_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .vld_i  (s_vld[k]),
      .tag_i  (s_tag[k]),
      .rad_i  (s_rad[k]),
      .root_i (s_root[k]),
      .rem_i  (s_rem[k]),
      .vld_o  (s_vld[k+1]),
      .tag_o  (s_tag[k+1]),
      .rad_o  (s_rad[k+1]),
      .root_o (s_root[k+1]),
      .rem_o  (s_rem[k+1])
    );
  end

  // ---------------- numerator stage ----------------
  localparam int QUO_W_T = lsi_pkg::QUO_W;

  logic signed [lsi_pkg::NUM_W-1:0] sx, bx, n0, n1;
  logic [lsi_pkg::NMAG_W-1:0]       mg0, mg1, hi0, hi1;
  logic [lsi_pkg::DEN_W-1:0]        den;
  logic                             big0, big1, fault;
  logic [QUO_W_T-1:0]               lo0, lo1;
  logic [1:0]                       cnt;

  always_comb begin
    sx    = $signed(lsi_pkg::NUM_W'(s_root[NR]));
    bx    = lsi_pkg::NUM_W'(s_tag[NR].bh) <<< 1;
    n0    = sx - bx;
    n1    = -sx - bx;
    mg0   = n0[lsi_pkg::NUM_W-1] ? lsi_pkg::NMAG_W'(-n0) : n0[lsi_pkg::NMAG_W-1:0];
    mg1   = n1[lsi_pkg::NUM_W-1] ? lsi_pkg::NMAG_W'(-n1) : n1[lsi_pkg::NMAG_W-1:0];
    den   = {s_tag[NR].a, 1'b0};
    hi0   = mg0 >> SHR;
    hi1   = mg1 >> SHR;
    big0  = hi0 >= lsi_pkg::NMAG_W'(den);
    big1  = hi1 >= lsi_pkg::NMAG_W'(den);
    lo0   = mg0[lsi_pkg::QUO_W-1:0] << FRAC_BITS;
    lo1   = mg1[lsi_pkg::QUO_W-1:0] << FRAC_BITS;
    fault = (s_tag[NR].a == '0);
    if (fault || s_tag[NR].qneg) begin
      cnt = lsi_pkg::CNT_NONE;
    end else if (s_tag[NR].qzero) begin
      cnt = lsi_pkg::CNT_ONE;
    end else begin
      cnt = lsi_pkg::CNT_TWO;
    end
  end

  logic                        nm_vld_r;
  lsi_pkg::div_tag_t           nm_tag_r;
  logic [lsi_pkg::DEN_W-1:0]   nm_den_r, nm_rem0_r, nm_rem1_r;
  logic [lsi_pkg::QUO_W-1:0]   nm_lo0_r, nm_lo1_r;

  // Start the division on the part above the 32 quotient bits
  always_ff @(posedge clk) begin
    if (adv) begin
      nm_tag_r.cnt   <= cnt;
      nm_tag_r.fault <= fault;
      nm_tag_r.neg0  <= n0[lsi_pkg::NUM_W-1];
      nm_tag_r.neg1  <= n1[lsi_pkg::NUM_W-1];
      nm_tag_r.big0  <= big0;
      nm_tag_r.big1  <= big1;
      nm_den_r       <= den;
      nm_rem0_r      <= big0 ? '0 : hi0[lsi_pkg::DEN_W-1:0];
      nm_rem1_r      <= big1 ? '0 : hi1[lsi_pkg::DEN_W-1:0];
      nm_lo0_r       <= lo0;
      nm_lo1_r       <= lo1;
    end
  end

  // ---------------- divider chain ----------------
  logic                        d_vld  [NQ+1];
  lsi_pkg::div_tag_t           d_tag  [NQ+1];
  logic [lsi_pkg::DEN_W-1:0]   d_den  [NQ+1];
  logic [lsi_pkg::DEN_W-1:0]   d_rem0 [NQ+1];
  logic [lsi_pkg::QUO_W-1:0]   d_lo0  [NQ+1];
  logic [lsi_pkg::QUO_W-1:0]   d_q0   [NQ+1];
  logic [lsi_pkg::DEN_W-1:0]   d_rem1 [NQ+1];
  logic [lsi_pkg::QUO_W-1:0]   d_lo1  [NQ+1];
  logic [lsi_pkg::QUO_W-1:0]   d_q1   [NQ+1];

  assign d_vld[0]  = nm_vld_r;
  assign d_tag[0]  = nm_tag_r;
  assign d_den[0]  = nm_den_r;
  assign d_rem0[0] = nm_rem0_r;
  assign d_lo0[0]  = nm_lo0_r;
  assign d_q0[0]   = '0;
  assign d_rem1[0] = nm_rem1_r;
  assign d_lo1[0]  = nm_lo1_r;
  assign d_q1[0]   = '0;

  for (genvar k = 0; k < NQ; k++) begin : g_div
    lsi_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .vld_i  (d_vld[k]),
      .tag_i  (d_tag[k]),
      .den_i  (d_den[k]),
      .rem0_i (d_rem0[k]),
      .lo0_i  (d_lo0[k]),
      .q0_i   (d_q0[k]),
      .rem1_i (d_rem1[k]),
      .lo1_i  (d_lo1[k]),
      .q1_i   (d_q1[k]),
      .vld_o  (d_vld[k+1]),
      .tag_o  (d_tag[k+1]),
      .den_o  (d_den[k+1]),
      .rem0_o (d_rem0[k+1]),
      .lo0_o  (d_lo0[k+1]),
      .q0_o   (d_q0[k+1]),
      .rem1_o (d_rem1[k+1]),
      .lo1_o  (d_lo1[k+1]),
      .q1_o   (d_q1[k+1])
    );
  end

  // ---------------- clamp, sign and assemble ----------------
  logic [lsi_pkg::QUO_W-1:0] lim0, lim1, cl0, cl1, rt0, rt1;
  logic                      sat0, sat1;
  lsi_pkg::out_t             res;

  always_comb begin
    lim0 = d_tag[NQ].neg0 ? lsi_pkg::LIM_NEG : lsi_pkg::LIM_POS;
    lim1 = d_tag[NQ].neg1 ? lsi_pkg::LIM_NEG : lsi_pkg::LIM_POS;
    sat0 = d_tag[NQ].big0 || (d_q0[NQ] > lim0);
    sat1 = d_tag[NQ].big1 || (d_q1[NQ] > lim1);
    cl0  = sat0 ? lim0 : d_q0[NQ];
    cl1  = sat1 ? lim1 : d_q1[NQ];
    rt0  = d_tag[NQ].neg0 ? (~cl0 + 1'b1) : cl0;
    rt1  = d_tag[NQ].neg1 ? (~cl1 + 1'b1) : cl1;
    res.root_count   = d_tag[NQ].cnt;
    res.divide_fault = d_tag[NQ].fault;
    res.root_first   = '0;
    res.root_second  = '0;
    res.saturated    = 1'b0;
    case (d_tag[NQ].cnt)
      lsi_pkg::CNT_ONE: begin
        res.root_first = rt0;
        res.saturated  = sat0;
      end
      lsi_pkg::CNT_TWO: begin
        res.root_first  = rt0;
        res.root_second = rt1;
        res.saturated   = sat0 | sat1;
      end
      default: begin
        res.saturated = 1'b0;
      end
    endcase
  end

  // ---------------- flow control and output register ----------------
  logic          out_valid_r;
  lsi_pkg::out_t out_data_r;

  assign v_last   = d_vld[NQ];
  assign out_free = !out_valid_r || out_ready;
  assign adv      = out_free || !v_last;
  assign in_ready = adv;

  // Advance the valid bits of the plain stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      qd_vld_r <= 1'b0;
      nm_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_valid;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      qd_vld_r <= m_vld[ND];
      nm_vld_r <= s_vld[NR];
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= v_last;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && v_last) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------- assertions ----------------
  `LSI_ASSERT_IMP(a_fault_no_roots, out_valid && out_data.divide_fault, out_data.root_count == lsi_pkg::CNT_NONE && out_data.root_first == '0 && !out_data.saturated, "fault request reported roots")
  `LSI_ASSERT_IMP(a_second_unused, out_valid && out_data.root_count != lsi_pkg::CNT_TWO, out_data.root_second == '0, "unused second root not zero")
  `LSI_ASSERT_IMP(a_stall_blocks_in, v_last && out_valid_r && !out_ready, !in_ready, "input taken while pipeline is blocked")
  `LSI_ASSERT_NXT(a_stall_keeps_last, v_last && out_valid_r && !out_ready, v_last, "last stage request dropped during stall")

endmodule
